### hw/rtl/hwc_pkg.sv
package hwc_pkg;

  // Sizes of the datapath
  localparam int COUNT_BITS     = 24;
  localparam int SINE_ADDR_BITS = 10;
  localparam int SINE_BITS      = 16;
  localparam int DAC_BITS       = 12;

  localparam int PHASE_W   = 32;
  localparam int ROM_ADDR_W = SINE_ADDR_BITS + 2;
  localparam int SINE_QUARTER = 1 << SINE_ADDR_BITS;
  localparam int SINE_PEAK = (1 << (SINE_BITS - 1)) - 1;
  localparam int DAC_MAX   = (1 << DAC_BITS) - 1;

  // Widths of the serial multiply and divide
  localparam int MAG_W = SINE_BITS - 1;          // sine magnitude
  localparam int WIN_W = SINE_BITS;              // peak minus cosine
  localparam int P1_W  = MAG_W + WIN_W;          // sine times window
  localparam int AMP_W = DAC_BITS;
  localparam int M_W   = P1_W + AMP_W;           // amplitude times the above
  localparam int D_W   = 2 * SINE_BITS - 1;      // divisor width
  localparam int Q_W   = DAC_BITS + 1;           // quotient width
  localparam int T_W   = Q_W + D_W;              // dividend width
  localparam int R_W   = Q_W + 2;                // signed code before clamping
  localparam int STEP_W = 5;

  // Divisor 2*S*S, and the offset that keeps the dividend positive
  localparam int DAC_OFFSET = 1 << DAC_BITS;
  localparam logic [63:0] DIV_CONST  = 64'(2) * 64'(SINE_PEAK) * 64'(SINE_PEAK);
  localparam logic [63:0] BASE_CONST = DIV_CONST * 64'(DAC_OFFSET) + DIV_CONST / 64'(2);

  // Configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_START_STEP  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_DELTA  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_STEP = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TOTAL       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DAC_MID     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_DAC_AMP     = 3'd5;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [MAG_W-1:0] sine_mag_t;
  typedef sine_mag_t sine_table_t [0:SINE_QUARTER];

  // Operands handed to the serial arithmetic unit
  typedef struct packed {
    sine_mag_t           s_mag;
    logic                s_neg;
    sine_mag_t           c_mag;
    logic                c_neg;
    logic [AMP_W-1:0]    amp;
    logic [DAC_BITS-1:0] mid;
  } arith_req_t;

  // Quarter-wave sine, Taylor series to 11th order in Q30, evaluated at elaboration
  function automatic sine_table_t build_sine_table();
    sine_table_t tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    int k;
    for (k = 0; k <= SINE_QUARTER; k++) begin
      x    = (64'(k) * HALF_PI_Q30 + 64'(SINE_QUARTER / 2)) >> SINE_ADDR_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - term;
      v = (sum * 64'(SINE_PEAK) + (64'd1 << 29)) >> 30;
      if (v > 64'(SINE_PEAK)) v = 64'(SINE_PEAK);
      tab[k] = v[MAG_W-1:0];
    end
    return tab;
  endfunction

endpackage

### hw/rtl/hann_windowed_linear_chirp_generator.sv
// Hann-windowed linear chirp generator.
// Each input beat on in_valid/in_ready is one DAC sample tick carrying the
// restart flag; each tick gives exactly one output beat on out_valid/out_ready
// with dac_code, in_chirp and finished.
// Users write registers on the cfg channel (cfg_index, cfg_data) only while
// no tick is in flight; the block does not enforce this, cfg_ready is always
// high. Between acceptance and out_valid, a tick inside the chirp runs two
// sine lookups in the registered ROM, a 16-step and a 12-step bit-serial
// multiply, one add, and a 13-step restoring division by the fixed scale.
// An idle or finished tick goes straight to the output with dac_mid. Ticks
// are handled one at a time; in_ready rises again as soon as the result sits
// in the output register.
// If the receiver stalls, the result waits in the output register and one
// more tick may be accepted and worked on; it is held until the register
// frees up.
// Reset clears all accumulators, sets the done flag (idle, dac_mid output)
// and loads the register reset values; dac_mid and dac_amp reset to mid-scale.
module hann_windowed_linear_chirp_generator
  import hwc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   restart,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [DAC_BITS-1:0]    dac_code,
  output logic                   in_chirp,
  output logic                   finished,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SIN    = 3'd1;
  localparam logic [2:0] ST_COS    = 3'd2;
  localparam logic [2:0] ST_LAUNCH = 3'd3;
  localparam logic [2:0] ST_BUSY   = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  // Configuration registers
  logic [PHASE_W-1:0]    start_phase_step;
  logic [PHASE_W-1:0]    phase_step_delta;
  logic [PHASE_W-1:0]    window_step;
  logic [COUNT_BITS-1:0] total_samples;
  logic [DAC_BITS-1:0]   dac_mid;
  logic [AMP_W-1:0]      dac_amp;

  // Generator state
  logic [2:0]            state;
  logic [COUNT_BITS-1:0] sample_index;
  logic [PHASE_W-1:0]    phase_acc;
  logic [PHASE_W-1:0]    phase_inc;
  logic [PHASE_W-1:0]    window_phase;
  logic                  done_flag;

  // Per-tick working values
  sine_mag_t             s_mag;
  logic                  s_neg;
  logic [DAC_BITS-1:0]   res_code;
  logic                  res_in;

  logic                  in_fire;
  logic                  idx_eff_zero;
  logic [COUNT_BITS-1:0] idx_eff;
  logic                  done_eff;
  logic                  skip;
  logic [COUNT_BITS:0]   idx_inc;
  logic [PHASE_W-1:0]    cos_phase;
  logic [ROM_ADDR_W-1:0] rom_addr;
  sine_mag_t             rom_mag;
  logic                  rom_neg;
  arith_req_t            req;
  logic                  arith_start;
  logic                  arith_done;
  logic [DAC_BITS-1:0]   arith_code;
  logic                  out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // Restart takes effect before this tick is judged
  assign idx_eff_zero = restart;
  assign idx_eff      = idx_eff_zero ? '0 : sample_index;
  assign done_eff     = restart ? 1'b0 : done_flag;
  assign skip         = done_eff || (total_samples < COUNT_BITS'(2)) ||
                        (idx_eff >= total_samples);
  assign idx_inc      = {1'b0, sample_index} + 1'b1;

  // One ROM shared between the chirp sine and the window cosine
  assign cos_phase = window_phase + 32'h4000_0000;
  assign rom_addr  = (state == ST_COS) ? cos_phase[PHASE_W-1 -: ROM_ADDR_W]
                                       : phase_acc[PHASE_W-1 -: ROM_ADDR_W];

  hwc_sine_rom u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .mag  (rom_mag),
    .neg  (rom_neg)
  );

  assign arith_start = (state == ST_LAUNCH);
  assign req = '{s_mag: s_mag, s_neg: s_neg, c_mag: rom_mag, c_neg: rom_neg,
                 amp: dac_amp, mid: dac_mid};

  hwc_serial_arith u_arith (
    .clk   (clk),
    .rst   (rst),
    .start (arith_start),
    .req   (req),
    .done  (arith_done),
    .code  (arith_code)
  );

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      start_phase_step <= '0;
      phase_step_delta <= '0;
      window_step      <= '0;
      total_samples    <= '0;
      dac_mid          <= DAC_BITS'(2048);
      dac_amp          <= AMP_W'(2047);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_START_STEP:  start_phase_step <= cfg_data;
        REG_STEP_DELTA:  phase_step_delta <= cfg_data;
        REG_WINDOW_STEP: window_step      <= cfg_data;
        REG_TOTAL:       total_samples    <= cfg_data[COUNT_BITS-1:0];
        REG_DAC_MID:     dac_mid          <= cfg_data[DAC_BITS-1:0];
        REG_DAC_AMP:     dac_amp          <= cfg_data[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Tick sequencer and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sample_index <= '0;
      phase_acc    <= '0;
      phase_inc    <= '0;
      window_phase <= '0;
      done_flag    <= 1'b1;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (restart) begin
              sample_index <= '0;
              phase_acc    <= '0;
              phase_inc    <= start_phase_step;
              window_phase <= '0;
            end
            if (skip) begin
              done_flag <= 1'b1;
              res_code  <= dac_mid;
              res_in    <= 1'b0;
              state     <= ST_EMIT;
            end else begin
              done_flag <= done_eff;
              res_in    <= 1'b1;
              state     <= ST_SIN;
            end
          end
        end
        ST_SIN: begin
          state <= ST_COS;
        end
        ST_COS: begin
          s_mag <= rom_mag;
          s_neg <= rom_neg;
          state <= ST_LAUNCH;
        end
        ST_LAUNCH: begin
          // Operands are captured by the arithmetic unit; step the chirp on
          sample_index <= idx_inc[COUNT_BITS-1:0];
          phase_acc    <= phase_acc + phase_inc;
          phase_inc    <= phase_inc + phase_step_delta;
          window_phase <= window_phase + window_step;
          done_flag    <= (idx_inc >= {1'b0, total_samples});
          state        <= ST_BUSY;
        end
        ST_BUSY: begin
          if (arith_done) begin
            res_code <= arith_code;
            state    <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: one beat per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      dac_code <= res_code;
      in_chirp <= res_in;
      finished <= done_flag;
    end
  end

endmodule

### hw/rtl/hwc_sine_rom.sv
module hwc_sine_rom
  import hwc_pkg::*;
(
  input  logic                  clk,
  input  logic [ROM_ADDR_W-1:0] addr,
  output sine_mag_t             mag,
  output logic                  neg
);

  localparam sine_table_t SineTable = build_sine_table();

  logic [1:0]                quad;
  logic [SINE_ADDR_BITS-1:0] idx;
  logic [SINE_ADDR_BITS:0]   rom_idx;

  // Quadrants 1 and 3 run the table backwards, 2 and 3 flip the sign
  assign quad    = addr[ROM_ADDR_W-1 -: 2];
  assign idx     = addr[SINE_ADDR_BITS-1:0];
  assign rom_idx = quad[0] ? ((SINE_ADDR_BITS+1)'(SINE_QUARTER) - {1'b0, idx})
                           : {1'b0, idx};

  // Registered read
  always_ff @(posedge clk) begin
    mag <= SineTable[rom_idx];
    neg <= quad[1];
  end

endmodule

### hw/rtl/hwc_serial_arith.sv
module hwc_serial_arith
  import hwc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  arith_req_t          req,
  output logic                done,
  output logic [DAC_BITS-1:0] code
);

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_MUL1 = 3'd1;
  localparam logic [2:0] A_MUL2 = 3'd2;
  localparam logic [2:0] A_PREP = 3'd3;
  localparam logic [2:0] A_DIV  = 3'd4;
  localparam logic [2:0] A_DONE = 3'd5;

  logic [2:0]          state;
  logic [STEP_W-1:0]   cnt;
  sine_mag_t           mag_a;
  logic                neg;
  logic [AMP_W-1:0]    amp;
  logic [DAC_BITS-1:0] mid;
  logic [P1_W-1:0]     p1;
  logic [M_W-1:0]      p2;
  logic [D_W-1:0]      rem;
  logic [Q_W-1:0]      qsh;

  logic [WIN_W-1:0]    win;
  logic [MAG_W:0]      sum1;
  logic [P1_W:0]       sum2;
  logic [T_W-1:0]      tval;
  logic [D_W:0]        rs;
  logic [D_W:0]        rs_sub;
  logic                ge;
  logic signed [R_W-1:0] r;

  // Window term: peak minus cosine
  assign win = req.c_neg ? (WIN_W'(SINE_PEAK) + WIN_W'(req.c_mag))
                         : (WIN_W'(SINE_PEAK) - WIN_W'(req.c_mag));

  // Shift-add steps, one multiplier bit a cycle
  assign sum1 = {1'b0, p1[P1_W-1:WIN_W]} + (p1[0] ? {1'b0, mag_a} : '0);
  assign sum2 = {1'b0, p2[M_W-1:AMP_W]} + (p2[0] ? {1'b0, p1} : '0);

  // Dividend with the sign applied, offset and rounding folded in
  assign tval = neg ? (T_W'(BASE_CONST) - T_W'(p2)) : (T_W'(BASE_CONST) + T_W'(p2));

  // Restoring division step
  assign rs     = {rem, qsh[Q_W-1]};
  assign rs_sub = rs - (D_W+1)'(DIV_CONST);
  assign ge     = rs >= (D_W+1)'(DIV_CONST);

  // Remove the offset and clamp to the DAC range
  assign r = $signed({{(R_W-DAC_BITS){1'b0}}, mid}) + $signed({{(R_W-Q_W){1'b0}}, qsh})
           - $signed(R_W'(DAC_OFFSET));

  always_comb begin
    if (r < 0) begin
      code = '0;
    end else if (r > $signed(R_W'(DAC_MAX))) begin
      code = DAC_BITS'(DAC_MAX);
    end else begin
      code = r[DAC_BITS-1:0];
    end
  end

  assign done = (state == A_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        A_IDLE: begin
          if (start) begin
            mag_a <= req.s_mag;
            neg   <= req.s_neg;
            amp   <= req.amp;
            mid   <= req.mid;
            p1    <= {{MAG_W{1'b0}}, win};
            cnt   <= '0;
            state <= A_MUL1;
          end
        end
        A_MUL1: begin
          p1 <= {sum1, p1[WIN_W-1:1]};
          if (cnt == STEP_W'(WIN_W - 1)) begin
            cnt   <= '0;
            state <= A_MUL2;
            p2    <= {{P1_W{1'b0}}, amp};
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        A_MUL2: begin
          p2 <= {sum2, p2[AMP_W-1:1]};
          if (cnt == STEP_W'(AMP_W - 1)) begin
            cnt   <= '0;
            state <= A_PREP;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        A_PREP: begin
          rem   <= tval[T_W-1:Q_W];
          qsh   <= tval[Q_W-1:0];
          state <= A_DIV;
        end
        A_DIV: begin
          rem <= ge ? rs_sub[D_W-1:0] : rs[D_W-1:0];
          qsh <= {qsh[Q_W-2:0], ge};
          if (cnt == STEP_W'(Q_W - 1)) begin
            cnt   <= '0;
            state <= A_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        A_DONE: begin
          state <= A_IDLE;
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

endmodule

### tb/hann_windowed_linear_chirp_generator_tb.sv
module hann_windowed_linear_chirp_generator_tb
  import hwc_pkg::*;
();

  // Indexes past the last register, writes to them must be dropped
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int RANDOM_TICKS = 1100;

  typedef struct packed {
    logic [DAC_BITS-1:0] code;
    logic                chirp_on;
    logic                done;
  } dac_sample_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   restart = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [DAC_BITS-1:0]    dac_code;
  logic                   in_chirp;
  logic                   finished;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  hann_windowed_linear_chirp_generator uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .restart   (restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dac_code  (dac_code),
    .in_chirp  (in_chirp),
    .finished  (finished),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor copy of registers and chirp state
  logic [31:0]           reg_start_step;
  logic [31:0]           reg_step_delta;
  logic [31:0]           reg_window_step;
  logic [23:0]           reg_total;
  logic [11:0]           reg_mid;
  logic [11:0]           reg_amp;
  logic [COUNT_BITS-1:0] chirp_index;
  logic [31:0]           chirp_phase;
  logic [31:0]           chirp_step;
  logic [31:0]           win_phase;
  logic                  chirp_done;

  longint sine_rom [0:SINE_QUARTER];

  dac_sample_t expected_samples [$];
  int  mismatches = 0;
  int  results_seen = 0;
  bit  no_idle = 1'b0;
  bit  tick_valid_high = 1'b0;

  // Quarter-wave table: Taylor series to 11th order in Q30
  function automatic void fill_sine_rom();
    longint unsigned x, x2, term, sum, v;
    int k, n;
    for (k = 0; k <= SINE_QUARTER; k++) begin
      x    = (64'(k) * HALF_PI_Q30 + 64'(SINE_QUARTER / 2)) / 64'(SINE_QUARTER);
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (n = 1; n <= 5; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      v = (sum * 64'(SINE_PEAK) + (64'd1 << 29)) >> 30;
      if (v > 64'(SINE_PEAK)) v = 64'(SINE_PEAK);
      sine_rom[k] = longint'(v);
    end
  endfunction

  // Signed sine of a phase: quadrant from the top two bits
  function automatic longint sine_at(input logic [31:0] ph);
    logic [ROM_ADDR_W-1:0]     addr;
    logic [SINE_ADDR_BITS-1:0] idx;
    longint                    mag;
    addr = ph[31 -: ROM_ADDR_W];
    idx  = addr[SINE_ADDR_BITS-1:0];
    mag  = addr[SINE_ADDR_BITS] ? sine_rom[SINE_QUARTER - int'(idx)] : sine_rom[idx];
    return addr[SINE_ADDR_BITS+1] ? -mag : mag;
  endfunction

  function automatic void reset_chirp_model();
    reg_start_step  = '0;
    reg_step_delta  = '0;
    reg_window_step = '0;
    reg_total       = '0;
    reg_mid         = 12'd2048;
    reg_amp         = 12'd2047;
    chirp_index     = '0;
    chirp_phase     = '0;
    chirp_step      = '0;
    win_phase       = '0;
    chirp_done      = 1'b1;
  endfunction

  function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_START_STEP:  reg_start_step  = val;
      REG_STEP_DELTA:  reg_step_delta  = val;
      REG_WINDOW_STEP: reg_window_step = val;
      REG_TOTAL:       reg_total       = val[23:0];
      REG_DAC_MID:     reg_mid         = val[11:0];
      REG_DAC_AMP:     reg_amp         = val[11:0];
      default: ;
    endcase
  endfunction

  // One sample tick: returns the code the block should emit and advances state
  function automatic dac_sample_t next_sample(input logic rs);
    dac_sample_t r;
    longint      s, c, dd, num, q;
    r.code     = reg_mid;
    r.chirp_on = 1'b0;
    if (rs) begin
      chirp_index = '0;
      chirp_phase = '0;
      chirp_step  = reg_start_step;
      win_phase   = '0;
      chirp_done  = 1'b0;
    end
    if (!chirp_done) begin
      if (reg_total < 2 || chirp_index >= reg_total) begin
        chirp_done = 1'b1;
      end else begin
        s   = sine_at(chirp_phase);
        c   = sine_at(win_phase + 32'h4000_0000);
        dd  = 2 * longint'(SINE_PEAK) * longint'(SINE_PEAK);
        num = longint'(reg_mid) * dd
            + longint'(reg_amp) * s * (longint'(SINE_PEAK) - c);
        if (num < 0) begin
          r.code = '0;
        end else begin
          q = (num + dd / 2) / dd;
          r.code = (q > DAC_MAX) ? DAC_BITS'(DAC_MAX) : q[DAC_BITS-1:0];
        end
        r.chirp_on  = 1'b1;
        chirp_index = chirp_index + 1'b1;
        chirp_phase = chirp_phase + chirp_step;
        chirp_step  = chirp_step + reg_step_delta;
        win_phase   = win_phase + reg_window_step;
        if (chirp_index >= reg_total) chirp_done = 1'b1;
      end
    end
    r.done = chirp_done;
    return r;
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 6);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, want %0d (result %0d)", what, got, want, results_seen);
    mismatches++;
  endtask

  // Send one tick beat, keeping valid high across back-to-back beats
  task automatic send_tick(input logic rs);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      if (tick_valid_high) begin
        in_valid <= 1'b0;
        tick_valid_high = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    restart  <= rs;
    tick_valid_high = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_samples.push_back(next_sample(rs));
  endtask

  // Stop sending and wait for every outstanding sample
  task automatic drain_ticks();
    if (tick_valid_high) begin
      in_valid <= 1'b0;
      tick_valid_high = 1'b0;
    end
    do @(posedge clk); while (expected_samples.size() != 0);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last beat
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
  endtask

  task automatic set_regs(input logic [31:0] start_step, input logic [31:0] delta,
                          input logic [31:0] wstep, input logic [31:0] total,
                          input logic [31:0] mid, input logic [31:0] amp);
    drain_ticks();
    write_reg(REG_START_STEP, start_step);
    write_reg(REG_STEP_DELTA, delta);
    write_reg(REG_WINDOW_STEP, wstep);
    write_reg(REG_TOTAL, total);
    write_reg(REG_DAC_MID, mid);
    write_reg(REG_DAC_AMP, amp);
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stalls, each beat checked against the oldest prediction
  initial begin
    dac_sample_t want;
    int gap;
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_seen++;
      if (expected_samples.size() == 0) begin
        report_mismatch("sample with nothing pending", dac_code, -1);
      end else begin
        want = expected_samples.pop_front();
        if (dac_code !== want.code) report_mismatch("dac_code", dac_code, want.code);
        if (in_chirp !== want.chirp_on) report_mismatch("in_chirp", in_chirp, want.chirp_on);
        if (finished !== want.done) report_mismatch("finished", finished, want.done);
      end
    end
  end

  // Idle after reset, then a restart with zero length
  task automatic test_reset_state();
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    drain_ticks();
  endtask

  // Lengths one and two: one gives no chirp, two gives two samples then idle
  task automatic test_short_chirp();
    set_regs(32'h1000_0000, 32'h0, 32'h8000_0000, 32'd1, 32'd2048, 32'd2047);
    send_tick(1'b1);
    set_regs(32'h1000_0000, 32'h0, 32'h8000_0000, 32'd2, 32'd2048, 32'd2047);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  // Full-scale code: top clamp, then a negative sum forced to zero
  task automatic test_code_clamp();
    set_regs(32'h4000_0000, 32'h0, 32'h8000_0000, 32'd3, 32'd4095, 32'd4095);
    send_tick(1'b1);
    send_tick(1'b0);
    set_regs(32'hC000_0000, 32'h0, 32'h8000_0000, 32'd3, 32'd0, 32'd4095);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  // Accumulators and increment wrapping, beats back to back
  task automatic test_wrap();
    set_regs(32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd5, 32'd1000, 32'd3000);
    no_idle = 1'b1;
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    drain_ticks();
    no_idle = 1'b0;
  endtask

  // Spare indexes must not disturb a running chirp
  task automatic test_spare_index();
    set_regs(32'h0123_4567, 32'h7FFF_FFFF, 32'h0400_0000, 32'd30, 32'd2048, 32'd2047);
    send_tick(1'b1);
    drain_ticks();
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_HI, 32'h0000_0000);
    cfg_valid <= 1'b0;
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  // Length cut below the index mid-chirp, then a restart part way through
  task automatic test_length_shrink();
    set_regs(32'h0200_0000, 32'h0001_0000, 32'h0800_0000, 32'd40, 32'd2048, 32'd2047);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    drain_ticks();
    write_reg(REG_TOTAL, 32'd2);
    cfg_valid <= 1'b0;
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  // Largest length: only the first few samples
  task automatic test_longest_length();
    set_regs(32'h0800_0000, 32'hFFFF_FF00, 32'd256, 32'h00FF_FFFF, 32'd2048, 32'd2047);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  function automatic logic [31:0] pick_reg_value(input logic [CFG_INDEX_W-1:0] idx);
    logic [31:0] v;
    v = $urandom;
    case (idx)
      REG_START_STEP: begin
        case ($urandom_range(0, 5))
          0: v = 32'h0;
          1: v = 32'hFFFF_FFFF;
          2: v = $urandom_range(0, 32'h0800_0000);
          default: ;
        endcase
      end
      REG_STEP_DELTA: begin
        case ($urandom_range(0, 6))
          0: v = 32'h0;
          1: v = 32'h8000_0000;
          2: v = 32'h7FFF_FFFF;
          3, 4: v = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
          default: ;
        endcase
      end
      REG_WINDOW_STEP: begin
        case ($urandom_range(0, 5))
          0: v = 32'h0;
          1: v = 32'hFFFF_FFFF;
          2, 3: if (reg_total > 1) v = 32'(64'h1_0000_0000 / 64'(reg_total - 1));
          default: ;
        endcase
      end
      REG_TOTAL: begin
        case ($urandom_range(0, 11))
          0: v[23:0] = $urandom_range(0, 1);
          1: v[23:0] = 24'hFF_FFFF;
          2: ;
          default: v[23:0] = $urandom_range(2, 64);
        endcase
      end
      REG_DAC_MID, REG_DAC_AMP: begin
        case ($urandom_range(0, 5))
          0: v[11:0] = 12'd0;
          1: v[11:0] = 12'd4095;
          default: ;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  // Random settings, each followed by ticks running past chirps of 64 or less
  task automatic test_random_chirps();
    int sent;
    int n;
    int i;
    logic [CFG_INDEX_W-1:0] idx;
    sent = 0;
    while (sent < RANDOM_TICKS) begin
      drain_ticks();
      no_idle = ($urandom_range(0, 3) == 0);
      for (i = 0; i < 6; i++) begin
        idx = CFG_INDEX_W'(i);
        if ($urandom_range(0, 3) != 0) write_reg(idx, pick_reg_value(idx));
      end
      if ($urandom_range(0, 7) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
      cfg_valid <= 1'b0;
      n = (reg_total <= 64) ? int'(reg_total) + $urandom_range(1, 4) : $urandom_range(8, 40);
      for (i = 0; i < n; i++) begin
        if (i == 0) send_tick($urandom_range(0, 9) != 0);
        else send_tick($urandom_range(0, 49) == 0);
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    int guard;
    fill_sine_rom();
    reset_chirp_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_short_chirp();
    test_code_clamp();
    test_wrap();
    test_spare_index();
    test_length_shrink();
    test_longest_length();
    test_random_chirps();

    // Let the last samples come out, then a margin for stray beats
    if (tick_valid_high) begin
      in_valid <= 1'b0;
      tick_valid_high = 1'b0;
    end
    guard = 0;
    while (expected_samples.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (64) @(posedge clk);
    if (expected_samples.size() != 0)
      report_mismatch("samples never emitted", expected_samples.size(), 0);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(12 * 3000000);
    $display("simulation failed");
    $finish;
  end

endmodule

### sim.f
hw/rtl/hwc_pkg.sv
hw/rtl/hwc_sine_rom.sv
hw/rtl/hwc_serial_arith.sv
hw/rtl/hann_windowed_linear_chirp_generator.sv
tb/hann_windowed_linear_chirp_generator_tb.sv
